// ===== hw/rtl/mcam_pkg.sv =====
// ----------------------------------------------------------------------------
// mcam_pkg: shared types and helpers for the matrix chain add/multiply unit
// Request/result payloads, opcodes, controller states, datapath commands and
// the Q16.16 saturation and rounding functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mcam_pkg;

  // Element and field widths fixed by the interface
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned SUM_W       = ELEM_W + 4;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned MAX_DIM_DEF = 8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ADD    = 2'd1,
    OP_MUL    = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ADD_ERR = 2'd1,
    ST_MUL_ERR = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic [DIM_W-1:0]          rows;
    logic [DIM_W-1:0]          cols;
    logic signed [ELEM_W-1:0]  value;
    logic                      last_element;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic [POS_W-1:0]          row_index;
    logic [POS_W-1:0]          col_index;
    logic signed [ELEM_W-1:0]  element;
    logic [DIM_W-1:0]          result_rows;
    logic [DIM_W-1:0]          result_cols;
    logic                      last_result;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_AD_RD,
    S_AD_WR,
    S_MU_RD,
    S_MU_MUL,
    S_MU_RND,
    S_MU_ACC,
    S_MU_WR,
    S_CP_RD,
    S_CP_WR,
    S_EM_RD,
    S_EM_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_LOAD,
    SRC_ADD,
    SRC_COPY
  } acc_src_e;

  // Controller to datapath command group
  typedef struct packed {
    logic     buf_we;
    logic     rd;
    logic     op_zero;
    logic     acc_we;
    acc_src_e acc_src;
    logic     mul_en;
    logic     rnd_en;
    logic     sum_acc;
    logic     sum_clr;
    logic     scr_we;
    logic     out_en;
    logic     err_out;
  } cmd_t;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // Saturate a wide sum to one element
  function automatic logic signed [ELEM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(ELEM_MAX);
    lo = SUM_W'(ELEM_MIN);
    if (v > hi) begin
      sat_sum = ELEM_MAX;
    end else if (v < lo) begin
      sat_sum = ELEM_MIN;
    end else begin
      sat_sum = v[ELEM_W-1:0];
    end
  endfunction

  // Round a Q32.32 product half up to Q16.16 and saturate
  function automatic logic signed [ELEM_W-1:0] round_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] hi;
    logic signed [PROD_W:0] lo;
    t  = (PROD_W+1)'(p) + (PROD_W+1)'(32768);
    t  = t >>> 16;
    hi = (PROD_W+1)'(ELEM_MAX);
    lo = (PROD_W+1)'(ELEM_MIN);
    if (t > hi) begin
      round_prod = ELEM_MAX;
    end else if (t < lo) begin
      round_prod = ELEM_MIN;
    end else begin
      round_prod = t[ELEM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_chain_add_multiply_unit.sv =====
// A non-last element is stored and the unit stays idle; a last element of a load or
// add walks a read and a write state per operand entry, a multiply a read, multiply,
// round and accumulate state per multiply-accumulate (R*C*K of them) plus a write
// and a copy per result entry. A finish streams results through read and output states,
// limited by the registered accumulator read; an error finish gives its result next cycle.
// Reset clears dimensions to 1x1, the element count and the error; memories keep data.
// ----------------------------------------------------------------------------
// matrix_chain_add_multiply_unit: Q16.16 matrix load/add/multiply chain
// Collects operand matrices one element per request and applies them to an
// accumulator matrix; a finish request streams the accumulator or an error.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_add_multiply_unit #(
  parameter int unsigned MAX_DIM = mcam_pkg::MAX_DIM_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire mcam_pkg::req_t req_i,
  output logic                busy_o,
  output mcam_pkg::res_t      res_o,
  output logic                res_valid_o
);

  localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  mcam_pkg::cmd_t cmd;
  mcam_pkg::res_t meta;
  logic [AW-1:0]  buf_waddr, buf_raddr, cell_addr;

  // Sequencer
  mcam_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .buf_waddr_o (buf_waddr),
    .buf_raddr_o (buf_raddr),
    .cell_addr_o (cell_addr),
    .meta_o      (meta)
  );

  // Memories and arithmetic
  mcam_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .buf_waddr_i (buf_waddr),
    .buf_raddr_i (buf_raddr),
    .cell_addr_i (cell_addr),
    .value_i     (req_i.value),
    .meta_i      (meta),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mcam_datapath.sv =====
// ----------------------------------------------------------------------------
// mcam_datapath: storage and arithmetic of the matrix chain unit
// Operand buffer, accumulator and product scratch memories, the multiply,
// round and dot-product sum chain, and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcam_datapath #(
  parameter int unsigned MAX_DIM = mcam_pkg::MAX_DIM_DEF,
  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM,
  localparam int unsigned AW     = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mcam_pkg::cmd_t                    cmd_i,
  input  wire logic [AW-1:0]                     buf_waddr_i,
  input  wire logic [AW-1:0]                     buf_raddr_i,
  input  wire logic [AW-1:0]                     cell_addr_i,
  input  wire logic signed [mcam_pkg::ELEM_W-1:0] value_i,
  input  wire mcam_pkg::res_t                    meta_i,
  output mcam_pkg::res_t                         res_o,
  output logic                                   res_valid_o
);

  logic signed [mcam_pkg::ELEM_W-1:0] buf_mem [CELLS];
  logic signed [mcam_pkg::ELEM_W-1:0] acc_mem [CELLS];
  logic signed [mcam_pkg::ELEM_W-1:0] scr_mem [CELLS];

  logic signed [mcam_pkg::ELEM_W-1:0] buf_rd_q, acc_rd_q, scr_rd_q;
  logic                               zero_q;
  logic signed [mcam_pkg::ELEM_W-1:0] opnd;
  logic signed [mcam_pkg::ELEM_W-1:0] acc_wdata;
  logic signed [mcam_pkg::PROD_W-1:0] prod_q;
  logic signed [mcam_pkg::ELEM_W-1:0] term_q;
  logic signed [mcam_pkg::SUM_W-1:0]  sum_q, sum_d;
  mcam_pkg::res_t                     res_q, res_d;
  logic                               res_valid_q;

  // Operand entries past the received count read as zero
  assign opnd = zero_q ? '0 : buf_rd_q;

  // Select accumulator write data
  always_comb begin
    unique case (cmd_i.acc_src)
      mcam_pkg::SRC_LOAD: acc_wdata = opnd;
      mcam_pkg::SRC_ADD:  acc_wdata = mcam_pkg::sat_sum(
                            mcam_pkg::SUM_W'(acc_rd_q) + mcam_pkg::SUM_W'(opnd));
      mcam_pkg::SRC_COPY: acc_wdata = scr_rd_q;
      default:            acc_wdata = opnd;
    endcase
  end

  // Operand buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      buf_mem[buf_waddr_i] <= value_i;
    end
    if (cmd_i.rd) begin
      buf_rd_q <= buf_mem[buf_raddr_i];
      zero_q   <= cmd_i.op_zero;
    end
  end

  // Accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_we) begin
      acc_mem[cell_addr_i] <= acc_wdata;
    end
    if (cmd_i.rd) begin
      acc_rd_q <= acc_mem[cell_addr_i];
    end
  end

  // Product scratch
  always_ff @(posedge clk_i) begin
    if (cmd_i.scr_we) begin
      scr_mem[cell_addr_i] <= mcam_pkg::sat_sum(sum_q);
    end
    if (cmd_i.rd) begin
      scr_rd_q <= scr_mem[cell_addr_i];
    end
  end

  // Multiply, round, then accumulate the dot product
  always_comb begin
    sum_d = sum_q;
    if (cmd_i.sum_clr) begin
      sum_d = '0;
    end else if (cmd_i.sum_acc) begin
      sum_d = sum_q + mcam_pkg::SUM_W'(term_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= acc_rd_q * opnd;
    end
    if (cmd_i.rnd_en) begin
      term_q <= mcam_pkg::round_prod(prod_q);
    end
    sum_q <= sum_d;
  end

  // Build the result
  always_comb begin
    res_d = meta_i;
    if (cmd_i.out_en) begin
      res_d.element = acc_rd_q;
    end else begin
      res_d.element = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en || cmd_i.err_out) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.out_en || cmd_i.err_out;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mcam_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcam_ctrl: sequencer of the matrix chain unit
// Takes requests, tracks dimensions, element count and error, and walks the
// load, add, multiply, copy and emit sweeps over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mcam_ctrl #(
  parameter int unsigned MAX_DIM = mcam_pkg::MAX_DIM_DEF,
  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM,
  localparam int unsigned AW     = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int unsigned CW     = $clog2(CELLS + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mcam_pkg::req_t  req_i,
  output logic                 busy_o,
  output mcam_pkg::cmd_t       cmd_o,
  output logic [AW-1:0]        buf_waddr_o,
  output logic [AW-1:0]        buf_raddr_o,
  output logic [AW-1:0]        cell_addr_o,
  output mcam_pkg::res_t       meta_o
);

  localparam logic [mcam_pkg::DIM_W-1:0] DIM_ONE = mcam_pkg::DIM_W'(1);
  localparam logic [mcam_pkg::DIM_W-1:0] DIM_MAX = mcam_pkg::DIM_W'(MAX_DIM);

  mcam_pkg::state_e              state_q, state_d;
  logic [mcam_pkg::DIM_W-1:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [mcam_pkg::DIM_W-1:0]    rows_q, rows_d, cols_q, cols_d;
  logic [mcam_pkg::DIM_W-1:0]    acc_rows_q, acc_rows_d, acc_cols_q, acc_cols_d;
  logic [CW-1:0]                 cnt_q, cnt_d, rcv_q, rcv_d, cnt_inc;
  mcam_pkg::status_e             err_q, err_d;

  logic                          accept;
  logic                          cnt_room;
  logic [mcam_pkg::DIM_W-1:0]    in_rows, in_cols;
  logic [mcam_pkg::DIM_W-1:0]    sw_rows, sw_cols;
  logic                          j_end, i_end;
  logic [mcam_pkg::IDX_W-1:0]    idx;
  logic [mcam_pkg::DIM_W-1:0]    col_sel;

  assign accept   = start_i && (state_q == mcam_pkg::S_IDLE);
  assign busy_o   = (state_q != mcam_pkg::S_IDLE);
  assign cnt_room = (cnt_q < CW'(CELLS));
  assign cnt_inc  = cnt_room ? (cnt_q + CW'(1)) : cnt_q;

  // Clamp request dimensions into 1..MAX_DIM
  always_comb begin
    in_rows = req_i.rows;
    in_cols = req_i.cols;
    if (req_i.rows == '0) begin
      in_rows = DIM_ONE;
    end else if (req_i.rows > DIM_MAX) begin
      in_rows = DIM_MAX;
    end
    if (req_i.cols == '0) begin
      in_cols = DIM_ONE;
    end else if (req_i.cols > DIM_MAX) begin
      in_cols = DIM_MAX;
    end
  end

  // Sweep bounds for the current state
  always_comb begin
    unique case (state_q)
      mcam_pkg::S_LD_RD, mcam_pkg::S_LD_WR,
      mcam_pkg::S_AD_RD, mcam_pkg::S_AD_WR: begin
        sw_rows = rows_q;
        sw_cols = cols_q;
      end
      mcam_pkg::S_EM_RD, mcam_pkg::S_EM_OUT: begin
        sw_rows = acc_rows_q;
        sw_cols = acc_cols_q;
      end
      default: begin
        sw_rows = acc_rows_q;
        sw_cols = cols_q;
      end
    endcase
  end

  assign j_end = ((j_q + DIM_ONE) == sw_cols);
  assign i_end = ((i_q + DIM_ONE) == sw_rows);

  // Addresses: multiply reads walk the inner index
  always_comb begin
    if (state_q == mcam_pkg::S_MU_RD) begin
      col_sel = k_q;
      idx     = mcam_pkg::IDX_W'(k_q) * mcam_pkg::IDX_W'(cols_q)
              + mcam_pkg::IDX_W'(j_q);
    end else begin
      col_sel = j_q;
      idx     = mcam_pkg::IDX_W'(i_q) * mcam_pkg::IDX_W'(cols_q)
              + mcam_pkg::IDX_W'(j_q);
    end
  end

  assign cell_addr_o = AW'(int'(i_q) * MAX_DIM + int'(col_sel));
  assign buf_raddr_o = AW'(idx);
  assign buf_waddr_o = AW'(cnt_q);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mcam_pkg::S_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      rows_q     <= DIM_ONE;
      cols_q     <= DIM_ONE;
      acc_rows_q <= DIM_ONE;
      acc_cols_q <= DIM_ONE;
      cnt_q      <= '0;
      rcv_q      <= '0;
      err_q      <= mcam_pkg::ST_OK;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      acc_rows_q <= acc_rows_d;
      acc_cols_q <= acc_cols_d;
      cnt_q      <= cnt_d;
      rcv_q      <= rcv_d;
      err_q      <= err_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    acc_rows_d = acc_rows_q;
    acc_cols_d = acc_cols_q;
    cnt_d      = cnt_q;
    rcv_d      = rcv_q;
    err_d      = err_q;
    cmd_o      = '0;
    cmd_o.acc_src = mcam_pkg::SRC_LOAD;
    cmd_o.op_zero = (idx >= mcam_pkg::IDX_W'(rcv_q));

    meta_o.status      = mcam_pkg::ST_OK;
    meta_o.row_index   = i_q[mcam_pkg::POS_W-1:0];
    meta_o.col_index   = j_q[mcam_pkg::POS_W-1:0];
    meta_o.element     = '0;
    meta_o.result_rows = acc_rows_q;
    meta_o.result_cols = acc_cols_q;
    meta_o.last_result = i_end && j_end;

    unique case (state_q)
      mcam_pkg::S_IDLE: begin
        cmd_o.sum_clr = 1'b1;
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (accept) begin
          if (req_i.operation == mcam_pkg::OP_FINISH) begin
            cnt_d = '0;
            if (err_q != mcam_pkg::ST_OK) begin
              cmd_o.err_out      = 1'b1;
              meta_o.status      = err_q;
              meta_o.row_index   = '0;
              meta_o.col_index   = '0;
              meta_o.last_result = 1'b1;
            end else begin
              state_d = mcam_pkg::S_EM_RD;
            end
          end else begin
            cmd_o.buf_we = cnt_room;
            cnt_d        = cnt_inc;
            if (req_i.last_element) begin
              rcv_d  = cnt_inc;
              cnt_d  = '0;
              rows_d = in_rows;
              cols_d = in_cols;
              priority if (req_i.operation == mcam_pkg::OP_LOAD) begin
                acc_rows_d = in_rows;
                acc_cols_d = in_cols;
                err_d      = mcam_pkg::ST_OK;
                state_d    = mcam_pkg::S_LD_RD;
              end else if (err_q != mcam_pkg::ST_OK) begin
                state_d = mcam_pkg::S_IDLE;
              end else if (req_i.operation == mcam_pkg::OP_ADD) begin
                if (in_rows != acc_rows_q || in_cols != acc_cols_q) begin
                  err_d = mcam_pkg::ST_ADD_ERR;
                end else begin
                  state_d = mcam_pkg::S_AD_RD;
                end
              end else begin
                if (in_rows != acc_cols_q) begin
                  err_d = mcam_pkg::ST_MUL_ERR;
                end else begin
                  state_d = mcam_pkg::S_MU_RD;
                end
              end
            end
          end
        end
      end

      mcam_pkg::S_LD_RD, mcam_pkg::S_AD_RD,
      mcam_pkg::S_CP_RD, mcam_pkg::S_EM_RD: begin
        cmd_o.rd = 1'b1;
        unique case (state_q)
          mcam_pkg::S_LD_RD: state_d = mcam_pkg::S_LD_WR;
          mcam_pkg::S_AD_RD: state_d = mcam_pkg::S_AD_WR;
          mcam_pkg::S_CP_RD: state_d = mcam_pkg::S_CP_WR;
          default:           state_d = mcam_pkg::S_EM_OUT;
        endcase
      end

      mcam_pkg::S_LD_WR, mcam_pkg::S_AD_WR,
      mcam_pkg::S_CP_WR, mcam_pkg::S_EM_OUT: begin
        unique case (state_q)
          mcam_pkg::S_LD_WR: begin
            cmd_o.acc_we  = 1'b1;
            cmd_o.acc_src = mcam_pkg::SRC_LOAD;
            state_d       = mcam_pkg::S_LD_RD;
          end
          mcam_pkg::S_AD_WR: begin
            cmd_o.acc_we  = 1'b1;
            cmd_o.acc_src = mcam_pkg::SRC_ADD;
            state_d       = mcam_pkg::S_AD_RD;
          end
          mcam_pkg::S_CP_WR: begin
            cmd_o.acc_we  = 1'b1;
            cmd_o.acc_src = mcam_pkg::SRC_COPY;
            state_d       = mcam_pkg::S_CP_RD;
          end
          default: begin
            cmd_o.out_en = 1'b1;
            state_d      = mcam_pkg::S_EM_RD;
          end
        endcase
        // Advance the row-major sweep
        if (!j_end) begin
          j_d = j_q + DIM_ONE;
        end else begin
          j_d = '0;
          if (!i_end) begin
            i_d = i_q + DIM_ONE;
          end else begin
            i_d     = '0;
            state_d = mcam_pkg::S_IDLE;
            if (state_q == mcam_pkg::S_CP_WR) begin
              acc_cols_d = cols_q;
            end
          end
        end
      end

      mcam_pkg::S_MU_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = mcam_pkg::S_MU_MUL;
      end

      mcam_pkg::S_MU_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = mcam_pkg::S_MU_RND;
      end

      mcam_pkg::S_MU_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = mcam_pkg::S_MU_ACC;
      end

      mcam_pkg::S_MU_ACC: begin
        cmd_o.sum_acc = 1'b1;
        if ((k_q + DIM_ONE) == rows_q) begin
          state_d = mcam_pkg::S_MU_WR;
        end else begin
          k_d     = k_q + DIM_ONE;
          state_d = mcam_pkg::S_MU_RD;
        end
      end

      mcam_pkg::S_MU_WR: begin
        cmd_o.scr_we  = 1'b1;
        cmd_o.sum_clr = 1'b1;
        k_d           = '0;
        state_d       = mcam_pkg::S_MU_RD;
        if (!j_end) begin
          j_d = j_q + DIM_ONE;
        end else begin
          j_d = '0;
          if (!i_end) begin
            i_d = i_q + DIM_ONE;
          end else begin
            i_d     = '0;
            state_d = mcam_pkg::S_CP_RD;
          end
        end
      end

      default: begin
        state_d = mcam_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcam_checker.sv =====
// ----------------------------------------------------------------------------
// mcam_checker: port-level checks for the matrix chain unit
// Watches result strobes and fields over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcam_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           busy_o,
  input wire mcam_pkg::res_t res_o,
  input wire logic           res_valid_o
);

  // An error result is a single, final, zero result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != mcam_pkg::ST_OK)
      |-> (res_o.last_result && res_o.element == '0 && res_o.row_index == '0))
    else $error("error result not single or not zero");

  // Result position lies inside the reported dimensions
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == mcam_pkg::ST_OK)
      |-> ({1'b0, res_o.row_index} < res_o.result_rows &&
           {1'b0, res_o.col_index} < res_o.result_cols))
    else $error("result position out of range");

  // A result that is not last is followed by a gap and then the next result of the run
  a_run_cadence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_result) |=> (!res_valid_o ##1 res_valid_o))
    else $error("result run broken");

  // The unit stays busy while a run is still streaming
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_result) |-> busy_o)
    else $error("idle during result run");

  // Dimensions are never zero
  a_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.result_rows != '0 && res_o.result_cols != '0))
    else $error("zero result dimension");

endmodule

bind matrix_chain_add_multiply_unit mcam_checker u_mcam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy_o      (busy_o),
  .res_o       (res_o),
  .res_valid_o (res_valid_o)
);

`default_nettype wire
